@@ src/dssm_pkg.sv @@
// Shared types and constants for the dual stack shared memory block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package dssm_pkg;

    localparam int WORD_W = 32;
    localparam int FILL_W = 11;

    localparam logic [FILL_W-1:0] SPACE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_PUSH_ONE = 2'd0,
        FUNC_PUSH_TWO = 2'd1,
        FUNC_POP_ONE  = 2'd2,
        FUNC_POP_TWO  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HELD,
        S_POP_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the item on the ports for later execution
        logic exec;      // execute one operation
        logic use_held;  // take the operation from the latched item
        logic finish;    // move the read word into the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read; // the selected operation is a pop from a non-empty stack
    } sts_t;

endpackage

`default_nettype wire

@@ src/dssm_ctrl.sv @@
// Controller state machine of the dual stack shared memory block.
// Depends on dssm_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module dssm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dssm_pkg::cmd_t     cmd,
    input  wire dssm_pkg::sts_t sts
);
    import dssm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (slot_free)
                    begin
                        cmd.exec = 1'b1;
                        if (sts.need_read)
                            state_next = S_POP_WAIT;
                        else
                            out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_HELD;
                    end
                end
            end
            S_HELD:
            begin
                cmd.use_held = 1'b1;
                if (slot_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.need_read)
                        state_next = S_POP_WAIT;
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_POP_WAIT:
            begin
                // The result register was freed when the pop was executed.
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/dssm_dpath.sv @@
// Datapath of the dual stack shared memory block: size register, fill
// counters, shared memory and result registers. Depends on dssm_pkg.
`default_nettype none

module dssm_dpath #(
    parameter int DEPTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [1:0]                      func,
    input  wire logic signed [dssm_pkg::WORD_W-1:0] push_value,
    input  wire logic                            cfg_valid,
    input  wire logic [dssm_pkg::FILL_W-1:0]     space_in_use,
    input  wire dssm_pkg::cmd_t                  cmd,
    output dssm_pkg::sts_t                       sts,
    output logic signed [dssm_pkg::WORD_W-1:0]   pop_value,
    output logic [1:0]                           status,
    output logic [dssm_pkg::FILL_W-1:0]          fill_one,
    output logic [dssm_pkg::FILL_W-1:0]          fill_two
);
    import dssm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int DW = $clog2(DEPTH + 1);
    localparam int EW = ((DW > FILL_W) ? DW : FILL_W) + 1;
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

    logic [FILL_W-1:0] space_reg;
    logic [FILL_W-1:0] count_one_reg, count_one_next;
    logic [FILL_W-1:0] count_two_reg, count_two_next;
    logic [1:0]        func_reg;
    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              zero_reg, zero_next;
    logic [WORD_W-1:0] pop_value_reg, pop_value_next;
    status_t           status_reg, status_next;

    logic [WORD_W-1:0] mem [DEPTH];

    func_t             op_func;
    logic [WORD_W-1:0] op_value;
    logic [EW-1:0]     space_e, one_e, two_e, size_e;
    logic              room;
    logic              wr_en, rd_en;
    logic [EW-1:0]     wr_addr_e, rd_addr_e;

    assign op_func  = func_t'(cmd.use_held ? func_reg : func);
    assign op_value = cmd.use_held ? value_reg : push_value;

    assign space_e = {{(EW-FILL_W){1'b0}}, space_reg};
    assign one_e   = {{(EW-FILL_W){1'b0}}, count_one_reg};
    assign two_e   = {{(EW-FILL_W){1'b0}}, count_two_reg};
    assign size_e  = (space_e > DEPTH_E) ? DEPTH_E : space_e;
    assign room    = (one_e + two_e) < size_e;

    assign sts.need_read = ((op_func == FUNC_POP_ONE) && (count_one_reg != '0)) ||
                           ((op_func == FUNC_POP_TWO) && (count_two_reg != '0));

    always_comb
    begin
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        zero_next      = zero_reg;
        status_next    = status_reg;
        pop_value_next = pop_value_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr_e      = one_e;
        rd_addr_e      = one_e - EW'(1);
        if (cmd.exec)
        begin
            pop_value_next = '0;
            status_next    = ST_OK;
            case (op_func)
                FUNC_PUSH_ONE:
                begin
                    if (room)
                    begin
                        wr_en          = 1'b1;
                        wr_addr_e      = one_e;
                        count_one_next = count_one_reg + FILL_W'(1);
                    end
                    else
                        status_next = ST_OVERFLOW;
                end
                FUNC_PUSH_TWO:
                begin
                    if (room)
                    begin
                        wr_en          = 1'b1;
                        wr_addr_e      = size_e - two_e - EW'(1);
                        count_two_next = count_two_reg + FILL_W'(1);
                    end
                    else
                        status_next = ST_OVERFLOW;
                end
                FUNC_POP_ONE:
                begin
                    if (count_one_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        rd_addr_e      = one_e - EW'(1);
                        zero_next      = 1'b0;
                        count_one_next = count_one_reg - FILL_W'(1);
                    end
                    else
                    begin
                        status_next    = ST_UNDERFLOW;
                        pop_value_next = '1;
                    end
                end
                default:
                begin
                    if (count_two_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        rd_addr_e      = size_e - two_e;
                        // A stack two that outgrew a shrunken size pops as zero.
                        zero_next      = two_e > size_e;
                        count_two_next = count_two_reg - FILL_W'(1);
                    end
                    else
                    begin
                        status_next    = ST_UNDERFLOW;
                        pop_value_next = '1;
                    end
                end
            endcase
        end
        if (cmd.finish)
            pop_value_next = zero_reg ? '0 : rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_reg     <= SPACE_RESET;
            count_one_reg <= '0;
            count_two_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                space_reg <= space_in_use;
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            value_reg <= push_value;
        end
        zero_reg      <= zero_next;
        status_reg    <= status_next;
        pop_value_reg <= pop_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr_e[AW-1:0]] <= op_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr_e[AW-1:0]];
    end

    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign fill_one  = count_one_reg;
    assign fill_two  = count_two_reg;

endmodule

`default_nettype wire

@@ src/dual_stack_shared_memory.sv @@
// Top level of the dual stack shared memory block.
// Depends on dssm_pkg, dssm_ctrl and dssm_dpath.
`default_nettype none

// Two LIFO stacks share one memory of DEPTH 32-bit words, of which the first
// space_in_use entries are in use (a larger setting is treated as DEPTH).
// Stack one grows upward from entry 0 and stack two grows downward from the
// top entry in use. Each item on the input channel pushes to or pops from
// one of the stacks; each gives exactly one result item carrying the popped
// word (-1 for a pop from an empty stack, 0 for a push), a status code
// (ok, overflow or underflow) and both fill levels after the operation. A
// refused push or pop leaves the stacks untouched. A push, whether taken or
// refused, and a refused pop put their result straight into the output
// register; every pop that removes an entry, including a pop of stack two
// that no longer lies inside a shrunken size, first waits in S_POP_WAIT,
// because the shared memory has a single registered read port. Results leave
// through an output register, and one further item is latched while a
// result waits to be taken. The size register may be rewritten only while
// the block is idle; fill levels are kept across such a write, and a pop
// from stack two after the size changed under it may return a word that was
// never written. There is no clearing pass after reset: the stacks start
// empty and entries are read only after writing.
module dual_stack_shared_memory #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           func,
    input  wire logic signed [dssm_pkg::WORD_W-1:0]   push_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [dssm_pkg::WORD_W-1:0]        pop_value,
    output logic [1:0]                                status,
    output logic [dssm_pkg::FILL_W-1:0]               fill_one,
    output logic [dssm_pkg::FILL_W-1:0]               fill_two,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dssm_pkg::FILL_W-1:0]          space_in_use
);
    import dssm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The size register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    dssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dssm_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .push_value   (push_value),
        .cfg_valid    (cfg_valid),
        .space_in_use (space_in_use),
        .cmd          (cmd),
        .sts          (sts),
        .pop_value    (pop_value),
        .status       (status),
        .fill_one     (fill_one),
        .fill_two     (fill_two)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the dual stack shared memory block.
// Depends on dssm_pkg and dual_stack_shared_memory, and through it on dssm_ctrl and dssm_dpath.
`default_nettype none

module testbench;

    import dssm_pkg::*;

    // The block is built with its default memory depth. The predictor keeps a
    // mirror of that many words.
    localparam int MEM_DEPTH  = 1024;
    // Cycles without any handshake on any channel before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Length of the long receiver hold-off that lets the block fill and stall.
    localparam int HOLD_CYCLES = 300;
    // Least number of random items in the phased part of the run.
    localparam int RANDOM_ITEMS = 480;
    // Shared size used when both stacks are run completely full.
    localparam int FULL_SIZE = 256;

    // One expected result item, at the widths of the output ports.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        status_t           st;
        logic [FILL_W-1:0] fill_one;
        logic [FILL_W-1:0] fill_two;
    } stack_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic [1:0]               func         = FUNC_PUSH_ONE;
    logic signed [WORD_W-1:0] push_value   = '0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_one;
    logic [FILL_W-1:0]        fill_two;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [FILL_W-1:0]        space_in_use = '0;

    // Predictor state: the size register, both fill levels and a mirror of the
    // shared memory. The written flags let the stimulus steer clear of reading
    // an entry that has never been written.
    logic [FILL_W-1:0]  space_reg = SPACE_RESET;
    int                 lvl_one   = 0;
    int                 lvl_two   = 0;
    logic [WORD_W-1:0]  mirror_mem     [0:MEM_DEPTH-1];
    bit                 mirror_written [0:MEM_DEPTH-1];

    stack_result_t      pending_results [$];
    stack_result_t      want;
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    int                 rx_span;

    // Idling is switched off for the closing part of the run; the hold-off
    // request is raised by a test and cleared by the receiver once served.
    bit                 idle_on     = 1'b1;
    bit                 hold_output = 1'b0;

    dual_stack_shared_memory #(
        .DEPTH (MEM_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pop_value    (pop_value),
        .status       (status),
        .fill_one     (fill_one),
        .fill_two     (fill_two),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .space_in_use (space_in_use)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The size that the stacks actually share: settings above the memory
    // depth are clipped to it.
    function automatic int shared_size();
        return (space_reg > MEM_DEPTH) ? MEM_DEPTH : int'(space_reg);
    endfunction

    // Applies one operation to the predictor and returns the result item the
    // block must give for it. Refused pushes and pops leave everything as it
    // was. A pop from stack two whose entry lies beyond a shrunken size gives
    // zero but still removes one entry.
    function automatic stack_result_t apply_op(func_t op, logic [WORD_W-1:0] word);
        stack_result_t r;
        int            size;
        size = shared_size();
        r.word = '0;
        r.st   = ST_OK;
        case (op)
            FUNC_PUSH_ONE:
            begin
                if (lvl_one + lvl_two < size)
                begin
                    mirror_mem[lvl_one]     = word;
                    mirror_written[lvl_one] = 1'b1;
                    lvl_one++;
                end
                else
                    r.st = ST_OVERFLOW;
            end
            FUNC_PUSH_TWO:
            begin
                if (lvl_one + lvl_two < size)
                begin
                    lvl_two++;
                    mirror_mem[size - lvl_two]     = word;
                    mirror_written[size - lvl_two] = 1'b1;
                end
                else
                    r.st = ST_OVERFLOW;
            end
            FUNC_POP_ONE:
            begin
                if (lvl_one > 0)
                begin
                    lvl_one--;
                    r.word = mirror_mem[lvl_one];
                end
                else
                begin
                    r.st   = ST_UNDERFLOW;
                    r.word = '1;
                end
            end
            default:
            begin
                if (lvl_two > 0)
                begin
                    r.word = (lvl_two <= size) ? mirror_mem[size - lvl_two] : '0;
                    lvl_two--;
                end
                else
                begin
                    r.st   = ST_UNDERFLOW;
                    r.word = '1;
                end
            end
        endcase
        r.fill_one = FILL_W'(lvl_one);
        r.fill_two = FILL_W'(lvl_two);
        return r;
    endfunction

    // Random push data, with the signed extremes, all ones and zero coming up
    // often enough to matter.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item on the input channel, after a random idle burst now and
    // then, and records the expected result once the item has been accepted.
    // A pop from stack two that would read a never-written entry (possible
    // only after the size moved under stack two) is turned into another
    // operation before it is offered.
    task automatic issue_op(input func_t op, input logic [WORD_W-1:0] word);
        int gap;
        int size;
        size = shared_size();
        if (op == FUNC_POP_TWO && lvl_two > 0 && lvl_two <= size
                && !mirror_written[size - lvl_two])
            op = (lvl_one > 0) ? FUNC_POP_ONE : FUNC_PUSH_ONE;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        func       <= op;
        push_value <= word;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_op(op, word));
    endtask

    // Rewrites the size register. The block must be idle first: the input is
    // withdrawn, every expected result is awaited, and then the pipeline is
    // left to settle.
    task automatic set_space(input logic [FILL_W-1:0] n);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid    <= 1'b1;
        space_in_use <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        space_reg = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Straight after reset, at the full size: pops from both empty stacks,
    // then the signed extremes, all ones and zero pushed to both stacks and
    // popped back in interleaved order.
    task automatic test_reset_state();
        issue_op(FUNC_POP_ONE, 32'h1234_5678);
        issue_op(FUNC_POP_TWO, 32'h1234_5678);
        issue_op(FUNC_PUSH_ONE, 32'h7FFF_FFFF);
        issue_op(FUNC_PUSH_TWO, 32'h8000_0000);
        issue_op(FUNC_PUSH_ONE, 32'hFFFF_FFFF);
        issue_op(FUNC_PUSH_TWO, 32'h0000_0000);
        issue_op(FUNC_POP_TWO, 32'h0);
        issue_op(FUNC_POP_ONE, 32'h0);
        issue_op(FUNC_POP_TWO, 32'h0);
        issue_op(FUNC_POP_ONE, 32'h0);
    endtask

    // With no shared space at all, every push overflows and every pop from
    // the empty stacks underflows.
    task automatic test_size_zero();
        set_space('0);
        issue_op(FUNC_PUSH_ONE, 32'h5555_5555);
        issue_op(FUNC_PUSH_TWO, 32'hAAAA_AAAA);
        issue_op(FUNC_POP_ONE, 32'h0);
        issue_op(FUNC_POP_TWO, 32'h0);
    endtask

    // A single shared entry: whichever stack takes it, the other one is
    // refused until it is freed again.
    task automatic test_size_one();
        set_space(11'd1);
        issue_op(FUNC_PUSH_ONE, 32'hAAAA_AAAA);
        issue_op(FUNC_PUSH_TWO, 32'h1111_1111);
        issue_op(FUNC_POP_ONE, 32'h0);
        issue_op(FUNC_PUSH_TWO, 32'h5555_5555);
        issue_op(FUNC_PUSH_ONE, 32'h2222_2222);
        issue_op(FUNC_POP_TWO, 32'h0);
    endtask

    // The size changes while both stacks hold data. After shrinking below the
    // combined fill, pushes overflow while pops go on; stack two's first pop
    // falls outside the new size and gives zero. Afterwards the size grows
    // and shrinks again, and finally a setting beyond the memory depth is
    // shown to act as the full depth.
    task automatic test_resize_with_data();
        set_space(11'd4);
        issue_op(FUNC_PUSH_TWO, 32'hA000_0003);
        issue_op(FUNC_PUSH_TWO, 32'hA000_0002);
        issue_op(FUNC_PUSH_TWO, 32'hA000_0001);
        issue_op(FUNC_PUSH_ONE, 32'hB000_0000);
        set_space(11'd2);
        issue_op(FUNC_PUSH_ONE, 32'hC000_0000);
        issue_op(FUNC_POP_TWO, 32'h0);
        issue_op(FUNC_POP_TWO, 32'h0);
        issue_op(FUNC_POP_TWO, 32'h0);
        issue_op(FUNC_POP_ONE, 32'h0);
        set_space(11'd8);
        issue_op(FUNC_PUSH_TWO, 32'hD000_0007);
        set_space(11'd4);
        issue_op(FUNC_POP_TWO, 32'h0);
        set_space(11'd2047);
        issue_op(FUNC_PUSH_TWO, 32'hE000_03FF);
        set_space(11'd1024);
        issue_op(FUNC_POP_TWO, 32'h0);
    endtask

    // Fills a shared size of FULL_SIZE entries with random pushes to both
    // stacks until no entry is free, tries a few more pushes that must
    // overflow, then drains both stacks with random pops. At the start the
    // receiver holds off for a long stretch, so the block fills up and stalls
    // its input.
    task automatic test_full_capacity();
        int k;
        set_space(FILL_W'(FULL_SIZE));
        hold_output = 1'b1;
        while (lvl_one + lvl_two < FULL_SIZE)
            issue_op(func_t'($urandom_range(0, 1)), pick_word());
        for (k = 0; k < 4; k++)
            issue_op(func_t'($urandom_range(0, 1)), pick_word());
        while (lvl_one + lvl_two > 0)
            issue_op(func_t'($urandom_range(2, 3)), pick_word());
    endtask

    // Random phases, each at a fresh size (mostly small) and with its own
    // balance of pushes and pops, so that the stacks keep running full and
    // empty. The fill levels carry over from phase to phase, so shrinking
    // below the current fill comes up regularly.
    task automatic test_random_phases();
        int done;
        int phase_len;
        int push_bias;
        int k;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       set_space(11'd0);
                1:       set_space(11'd1);
                2:       set_space(11'd2);
                3:       set_space(FILL_W'($urandom_range(1025, 2046)));
                default: set_space(FILL_W'($urandom_range(3, 40)));
            endcase
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 80);
            push_bias = $urandom_range(15, 85);
            for (k = 0; k < phase_len; k++)
            begin
                if ($urandom_range(0, 99) < push_bias)
                    issue_op(func_t'($urandom_range(0, 1)), pick_word());
                else
                    issue_op(func_t'($urandom_range(2, 3)), pick_word());
            end
            done += phase_len;
        end
    endtask

    // Closing stretch with no idling on either side, so items and results
    // flow back to back.
    task automatic test_steady_flow();
        int k;
        idle_on = 1'b0;
        set_space(11'd16);
        for (k = 0; k < 150; k++)
            issue_op(func_t'($urandom_range(0, 3)), pick_word());
    endtask

    // Receiver: ready in random runs, dropped in random idle bursts while
    // idling is on, and held low for a long stretch when a test asks for it.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_output = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rx_span = $urandom_range(1, 17);
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (rx_span - 1) @(negedge clk);
            end
            else
            begin
                rx_span = $urandom_range(1, 24);
                @(negedge clk);
                out_ready <= 1'b1;
                repeat (rx_span - 1) @(negedge clk);
            end
        end
    end

    // Every accepted result item is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: pop_value %h status %0d",
                       pop_value, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (pop_value !== want.word)
                begin
                    $error("pop_value: expected %h, got %h", want.word, pop_value);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    mismatch_count++;
                end
                if (fill_one !== want.fill_one)
                begin
                    $error("fill_one: expected %0d, got %0d", want.fill_one, fill_one);
                    mismatch_count++;
                end
                if (fill_two !== want.fill_two)
                begin
                    $error("fill_two: expected %0d, got %0d", want.fill_two, fill_two);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles in which no channel completes a
    // handshake means the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $error("no handshake for %0d cycles, %0d results outstanding",
                           quiet_cycles, pending_results.size());
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Reset is held from the start and released on a falling edge; the
    // tests then run in turn, and the run ends once every expected result
    // has arrived and a short settling time has shown nothing more comes.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_size_zero();
        test_size_one();
        test_resize_with_data();
        test_full_capacity();
        test_random_phases();
        test_steady_flow();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ dual_stack_shared_memory.f @@
src/dssm_pkg.sv
src/dssm_ctrl.sv
src/dssm_dpath.sv
src/dual_stack_shared_memory.sv
tb/testbench.sv
